// File: rtl/core/htsef_pkg.sv
// Shared types and constants for the header table size and eviction block.
package htsef_pkg;

  // Command codes
  localparam logic [1:0] CMD_INSERT    = 2'd0;
  localparam logic [1:0] CMD_LOOKUP    = 2'd1;
  localparam logic [1:0] CMD_SET_LIMIT = 2'd2;
  localparam logic [1:0] CMD_NONE      = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // Field widths
  localparam int LEN_W   = 13;
  localparam int ID_W    = 32;
  localparam int ESIZE_W = 14;
  localparam int USED_W  = 13;
  localparam int EV_W    = 8;
  // Exact entry size: two 13-bit lengths plus overhead
  localparam int SZ_W    = 15;

  localparam int unsigned ENTRY_OVERHEAD = 32;
  localparam logic [ESIZE_W-1:0] ESIZE_SAT = 14'h3FFF;

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QAW     = 1;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [LEN_W-1:0] name_len;
    logic [LEN_W-1:0] value_len;
    logic [ID_W-1:0]  lookup_id;
    logic [ID_W-1:0]  new_limit;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ID_W-1:0]    entry_id;
    logic [ESIZE_W-1:0] entry_size;
    logic [USED_W-1:0]  used_size;
    logic [EV_W-1:0]    evicted;
  } out_item_t;

  // Classified command as it waits in the queue
  typedef struct packed {
    logic [1:0]      cmd;
    logic [SZ_W-1:0] size;
    logic [ID_W-1:0] arg;
  } op_t;

endpackage

// File: rtl/core/htsef_ram.sv
// Generic single-write, single-read RAM with registered read data.
module htsef_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/htsef_queue.sv
// Two-entry command queue between the front and back parts.
module htsef_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  htsef_pkg::op_t push_op,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output htsef_pkg::op_t head
);
  import htsef_pkg::*;

  op_t            slots [Q_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   fill;

  assign full       = (fill == (QAW+1)'(Q_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  // Advance pointers and fill level; store pushed item
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_op;
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule

// File: rtl/core/htsef_front.sv
// Front part: accepts request items, computes entry size and picks the argument.
module htsef_front (
  input  logic                req_valid,
  output logic                req_stall,
  input  htsef_pkg::in_item_t req,
  input  logic                q_full,
  output logic                push,
  output htsef_pkg::op_t      push_op
);
  import htsef_pkg::*;

  // Stall while the queue has no room
  assign req_stall = q_full;
  assign push      = req_valid && !q_full;

  // Classify: exact size for inserts, id or limit as the argument
  always_comb begin
    push_op.cmd  = req.cmd;
    push_op.size = SZ_W'(req.name_len) + SZ_W'(req.value_len) + SZ_W'(ENTRY_OVERHEAD);
    push_op.arg  = (req.cmd == CMD_LOOKUP) ? req.lookup_id : req.new_limit;
  end

endmodule

// File: rtl/core/htsef_back.sv
// Back part: table state, eviction sequencer, size RAM and result register.
module htsef_back #(
  parameter int LIMIT_MAX   = 4096,
  parameter int MAX_ENTRIES = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  htsef_pkg::op_t       q_head,
  output logic                 q_pop,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output htsef_pkg::out_item_t rsp
);
  import htsef_pkg::*;

  localparam int SW   = $clog2(LIMIT_MAX + 1);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int AW   = $clog2(MAX_ENTRIES);
  localparam int EVW  = (CW > EV_W) ? CW : EV_W;
  localparam int CMPW = (SW > SZ_W) ? SW : SZ_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVICT = 2'd1;
  localparam logic [1:0] S_DROP  = 2'd2;
  localparam logic [1:0] S_LOOK  = 2'd3;

  logic [1:0]      state;
  logic [AW-1:0]   oldest;
  logic [CW-1:0]   count;
  logic [SW-1:0]   total;
  logic [ID_W-1:0] next_id;
  logic [SW-1:0]   table_limit;

  // Current command
  logic [1:0]      op_cmd;
  logic [SZ_W-1:0] op_size;
  logic            op_big;
  logic [SW-1:0]   bound;
  logic [EVW-1:0]  ev;
  logic            look_hit_q;
  logic [ID_W-1:0] look_id;

  logic            rsp_free;
  logic            rsp_load;
  logic [SW-1:0]   lim_sat;
  logic [CMPW-1:0] size_ext;
  logic [CMPW-1:0] limit_ext;
  logic            ins_big;
  logic [SW-1:0]   ins_bound;
  logic [ID_W-1:0] look_dist;
  logic            look_hit;
  logic [CW-1:0]   look_off;
  logic [AW-1:0]   look_slot;
  logic [AW-1:0]   app_slot;
  logic [SW-1:0]   total_held;
  logic [SW-1:0]   new_total;
  logic            ins_ok;
  logic            drop;
  logic            ram_we;
  logic [AW-1:0]   ram_raddr;
  logic [SW-1:0]   ram_rdata;

  // Ring index of base plus offset; the sum stays below twice the depth
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] ofs);
    logic [AW:0] s;
    s = (AW+1)'(base) + (AW+1)'(ofs);
    if (s >= (AW+1)'(MAX_ENTRIES)) begin
      s = s - (AW+1)'(MAX_ENTRIES);
    end
    return s[AW-1:0];
  endfunction

  // Decode the queue head
  always_comb begin
    rsp_free  = !rsp_valid || !rsp_stall;
    q_pop     = (state == S_IDLE) && q_valid && rsp_free;
    lim_sat   = (q_head.arg > 32'(LIMIT_MAX)) ? SW'(LIMIT_MAX) : SW'(q_head.arg);
    size_ext  = CMPW'(q_head.size);
    limit_ext = CMPW'(table_limit);
    ins_big   = size_ext > limit_ext;
    ins_bound = ins_big ? '0 : SW'(limit_ext - size_ext);
    look_dist = next_id - q_head.arg;
    look_hit  = (look_dist != '0) && (look_dist <= 32'(count));
    look_off  = count - CW'(look_dist);
    look_slot = ring_add(oldest, look_off);
  end

  // Eviction decision and completion values
  always_comb begin
    ins_ok     = (op_cmd == CMD_INSERT) && !op_big;
    drop       = (count != '0) &&
                 ((total > bound) || (ins_ok && (count == CW'(MAX_ENTRIES))));
    total_held = (count == '0) ? '0 : total;
    new_total  = total_held + SW'(op_size);
    app_slot   = ring_add(oldest, count);
    ram_we     = (state == S_EVICT) && !drop && ins_ok;
    ram_raddr  = (state == S_IDLE) ? look_slot : oldest;
    rsp_load   = ((state == S_IDLE) && q_pop && (q_head.cmd == CMD_NONE)) ||
                 ((state == S_EVICT) && !drop) ||
                 (state == S_LOOK);
  end

  htsef_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_ENTRIES)
  ) u_sizes (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (app_slot),
    .wr_data (SW'(op_size)),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Load a new result, or release one that was taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Sequence commands, evictions and results
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      oldest      <= '0;
      count       <= '0;
      total       <= '0;
      next_id     <= 32'd1;
      table_limit <= SW'(LIMIT_MAX);
    end else begin
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            op_cmd  <= q_head.cmd;
            op_size <= q_head.size;
            ev      <= '0;
            case (q_head.cmd)
              CMD_INSERT: begin
                op_big <= ins_big;
                bound  <= ins_bound;
                state  <= S_EVICT;
              end
              CMD_SET_LIMIT: begin
                table_limit <= lim_sat;
                bound       <= lim_sat;
                op_big      <= 1'b0;
                state       <= S_EVICT;
              end
              CMD_LOOKUP: begin
                look_hit_q <= look_hit;
                look_id    <= q_head.arg;
                state      <= S_LOOK;
              end
              default: begin
                rsp.status     <= ST_OK;
                rsp.entry_id   <= '0;
                rsp.entry_size <= '0;
                rsp.used_size  <= USED_W'(total);
                rsp.evicted    <= '0;
              end
            endcase
          end
        end
        S_EVICT: begin
          if (drop) begin
            state <= S_DROP;
          end else begin
            state         <= S_IDLE;
            rsp.evicted   <= EV_W'(ev);
            if (ins_ok) begin
              count          <= count + 1'b1;
              total          <= new_total;
              next_id        <= next_id + 1'b1;
              rsp.status     <= ST_OK;
              rsp.entry_id   <= next_id;
              rsp.entry_size <= ESIZE_W'(op_size);
              rsp.used_size  <= USED_W'(new_total);
            end else begin
              total          <= total_held;
              rsp.entry_id   <= '0;
              rsp.used_size  <= USED_W'(total_held);
              if (op_cmd == CMD_INSERT) begin
                rsp.status     <= ST_TOO_LARGE;
                rsp.entry_size <= (op_size > SZ_W'(ESIZE_SAT)) ? ESIZE_SAT
                                                                : ESIZE_W'(op_size);
              end else begin
                rsp.status     <= ST_OK;
                rsp.entry_size <= '0;
              end
            end
          end
        end
        S_DROP: begin
          // Drop the oldest entry; its size is on the RAM read port now
          total  <= (total >= ram_rdata) ? total - ram_rdata : '0;
          oldest <= (oldest == AW'(MAX_ENTRIES - 1)) ? '0 : oldest + 1'b1;
          count  <= count - 1'b1;
          ev     <= ev + 1'b1;
          state  <= S_EVICT;
        end
        S_LOOK: begin
          state         <= S_IDLE;
          rsp.used_size <= USED_W'(total);
          rsp.evicted   <= '0;
          if (look_hit_q) begin
            rsp.status     <= ST_OK;
            rsp.entry_id   <= look_id;
            rsp.entry_size <= ESIZE_W'(ram_rdata);
          end else begin
            rsp.status     <= ST_NOT_FOUND;
            rsp.entry_id   <= '0;
            rsp.entry_size <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/header_table_size_evict_fifo.sv
// Accepted item to result: queued, popped by the back sequencer while idle (an
// unused command loads the result on pop), then insert and set limit pass the
// evict state, lookup the look state, and each evicted entry adds a drop pass
// (size RAM read, subtract); a 2-entry queue takes items while one is in work.
// Reset (rst, synchronous): table empty, next id 1, limit LIMIT_MAX, queue and
// result register empty. No clearing pass; RAM contents stay as they were.
module header_table_size_evict_fifo #(
  parameter int LIMIT_MAX   = 4096,
  parameter int MAX_ENTRIES = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  htsef_pkg::in_item_t  req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output htsef_pkg::out_item_t rsp
);
  import htsef_pkg::*;

  logic q_full;
  logic push;
  op_t  push_op;
  logic pop;
  logic head_valid;
  op_t  head;

  htsef_front u_front (
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op)
  );

  htsef_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  htsef_back #(
    .LIMIT_MAX   (LIMIT_MAX),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (head_valid),
    .q_head    (head),
    .q_pop     (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// File: rtl/core/htsef_checker.sv
// Port-level checks for the header table block, bound to the top level.
module htsef_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 rsp_valid,
  input logic                 rsp_stall,
  input htsef_pkg::out_item_t rsp
);
  import htsef_pkg::*;

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed or dropped");

  // Report no result right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  // A miss carries no id, no size and no eviction
  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_NOT_FOUND |->
      rsp.entry_id == '0 && rsp.entry_size == '0 && rsp.evicted == '0)
    else $error("lookup miss with payload");

  // A too large insert leaves the table empty
  a_big_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_TOO_LARGE |->
      rsp.entry_id == '0 && rsp.used_size == '0)
    else $error("too large insert left entries");

endmodule

bind header_table_size_evict_fifo htsef_checker u_checker (.*);

// File: tb/header_table_size_evict_fifo_test.sv
// Self-checking testbench for the header table size and eviction block.
module header_table_size_evict_fifo_test;
  import htsef_pkg::*;

  localparam int TABLE_LIMIT_MAX = 4096;
  localparam int TABLE_SLOTS     = 128;
  localparam int ITEM_TARGET     = 1300;
  localparam int QUIET_START     = 1100;
  localparam int SETTLE_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT  = 5000;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  in_item_t  req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  out_item_t rsp;

  header_table_size_evict_fifo u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Shadow copy of the table accounting
  logic [USED_W-1:0] slot_size [TABLE_SLOTS];
  logic [6:0]        head_slot  = '0;
  logic [7:0]        live_count = '0;
  logic [USED_W-1:0] live_total = '0;
  logic [ID_W-1:0]   next_id    = 1;
  logic [USED_W-1:0] cur_limit  = USED_W'(TABLE_LIMIT_MAX);

  // Stimulus planning state, tracked as items are queued
  logic [ID_W-1:0] plan_next_id = 1;
  int              plan_limit   = TABLE_LIMIT_MAX;
  int              planned      = 0;

  in_item_t  pending_reqs [$];
  out_item_t awaited_rsps [$];

  logic no_idle      = 1'b0;
  logic req_taken    = 1'b0;
  int   req_gap      = 0;
  int   rsp_gap      = 0;
  int   cycle_no     = 0;
  int   idle_cycles  = 0;
  int   mismatches   = 0;

  // Remove the oldest entry from the shadow table
  function automatic void retire_oldest();
    logic [USED_W-1:0] sz;
    sz = slot_size[head_slot];
    live_total = (live_total >= sz) ? live_total - sz : '0;
    head_slot = head_slot + 7'd1;
    live_count = live_count - 8'd1;
  endfunction

  // Evict oldest entries until the total fits under bound
  function automatic logic [EV_W-1:0] evict_down_to(input logic [USED_W-1:0] bound);
    logic [EV_W-1:0] n;
    n = '0;
    while (live_total > bound && live_count != 0) begin
      retire_oldest();
      n = n + 1'b1;
    end
    if (live_count == 0) live_total = '0;
    return n;
  endfunction

  // Apply one item to the shadow table and return the result it causes
  function automatic out_item_t predict_result(input in_item_t it);
    out_item_t       r;
    logic [SZ_W-1:0] sz;
    logic [ID_W-1:0] id_gap;
    logic [7:0]      off;
    logic [6:0]      slot;
    r = '0;
    case (it.cmd)
      CMD_INSERT: begin
        sz = SZ_W'(it.name_len) + SZ_W'(it.value_len) + SZ_W'(ENTRY_OVERHEAD);
        if (sz > cur_limit) begin
          // too large: empty the table, store nothing
          r.evicted = evict_down_to('0);
          r.status = ST_TOO_LARGE;
          r.entry_size = (sz > ESIZE_SAT) ? ESIZE_SAT : sz[ESIZE_W-1:0];
        end else begin
          r.evicted = evict_down_to(cur_limit - sz[USED_W-1:0]);
          while (live_count >= TABLE_SLOTS) begin
            retire_oldest();
            r.evicted = r.evicted + 1'b1;
          end
          slot = head_slot + live_count[6:0];
          slot_size[slot] = sz[USED_W-1:0];
          live_count = live_count + 8'd1;
          live_total = live_total + sz[USED_W-1:0];
          r.status = ST_OK;
          r.entry_id = next_id;
          r.entry_size = sz[ESIZE_W-1:0];
          next_id = next_id + 1;
        end
      end
      CMD_LOOKUP: begin
        // hit when the id is among the live ids just below the next one
        id_gap = next_id - it.lookup_id;
        if (id_gap >= 1 && id_gap <= live_count) begin
          off = live_count - id_gap[7:0];
          slot = head_slot + off[6:0];
          r.status = ST_OK;
          r.entry_id = it.lookup_id;
          r.entry_size = ESIZE_W'(slot_size[slot]);
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      CMD_SET_LIMIT: begin
        if (it.new_limit > TABLE_LIMIT_MAX) cur_limit = USED_W'(TABLE_LIMIT_MAX);
        else cur_limit = it.new_limit[USED_W-1:0];
        r.evicted = evict_down_to(cur_limit);
      end
      default: ;
    endcase
    r.used_size = live_total;
    return r;
  endfunction

  function automatic void compare_field(input string field, input logic [ID_W-1:0] want,
                                        input logic [ID_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  function automatic in_item_t make_item(input logic [1:0] cmd, input int nlen, input int vlen,
                                         input logic [ID_W-1:0] qid,
                                         input logic [ID_W-1:0] lim);
    in_item_t it;
    it.cmd = cmd;
    it.name_len = LEN_W'(nlen);
    it.value_len = LEN_W'(vlen);
    it.lookup_id = qid;
    it.new_limit = lim;
    return it;
  endfunction

  function automatic in_item_t random_fields();
    in_item_t it;
    it.cmd = 2'($urandom);
    it.name_len = LEN_W'($urandom);
    it.value_len = LEN_W'($urandom);
    it.lookup_id = $urandom;
    it.new_limit = $urandom;
    return it;
  endfunction

  // Pick one random operation, biased toward small entries and live ids
  function automatic in_item_t random_op();
    in_item_t it;
    int       pick;
    it = random_fields();
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      it.cmd = CMD_INSERT;
      pick = $urandom_range(0, 19);
      if (pick < 17) begin
        it.name_len = LEN_W'($urandom_range(0, 300));
        it.value_len = LEN_W'($urandom_range(0, 300));
      end else if (pick < 19) begin
        it.name_len = LEN_W'($urandom_range(0, 4096));
        it.value_len = LEN_W'($urandom_range(0, 4096));
      end
    end else if (pick < 80) begin
      it.cmd = CMD_LOOKUP;
      pick = $urandom_range(0, 19);
      if (pick < 14) it.lookup_id = plan_next_id - $urandom_range(1, 40);
      else if (pick < 17) it.lookup_id = plan_next_id - $urandom_range(0, 200);
    end else if (pick < 93) begin
      it.cmd = CMD_SET_LIMIT;
      pick = $urandom_range(0, 9);
      if (pick < 6) it.new_limit = $urandom_range(200, TABLE_LIMIT_MAX);
      else if (pick < 8) it.new_limit = $urandom_range(0, 200);
      else if (pick < 9) it.new_limit = $urandom_range(TABLE_LIMIT_MAX + 1, 70000);
    end else begin
      it.cmd = CMD_NONE;
    end
    return it;
  endfunction

  task automatic queue_item(input in_item_t it);
    pending_reqs.push_back(it);
    planned++;
    if (it.cmd == CMD_INSERT && it.name_len + it.value_len + ENTRY_OVERHEAD <= plan_limit)
      plan_next_id = plan_next_id + 1;
    else if (it.cmd == CMD_SET_LIMIT)
      plan_limit = (it.new_limit > TABLE_LIMIT_MAX) ? TABLE_LIMIT_MAX : it.new_limit;
  endtask

  // Fill the ring with mostly minimum size entries, probe it, then evict in bulk
  task automatic queue_fill_burst();
    in_item_t it;
    int       n;
    logic     jitter;
    it = random_fields();
    it.cmd = CMD_SET_LIMIT;
    it.new_limit = TABLE_LIMIT_MAX;
    queue_item(it);
    n = $urandom_range(120, 140);
    jitter = 1'($urandom_range(0, 1));
    repeat (n) begin
      it = random_fields();
      it.cmd = CMD_INSERT;
      it.name_len = (jitter && $urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, 8)) : '0;
      it.value_len = '0;
      queue_item(it);
    end
    it = random_fields();
    it.cmd = CMD_LOOKUP;
    it.lookup_id = plan_next_id - 1;
    queue_item(it);
    it.lookup_id = plan_next_id - $urandom_range(100, 140);
    queue_item(it);
    it = random_fields();
    if ($urandom_range(0, 1) == 0) begin
      it.cmd = CMD_SET_LIMIT;
      it.new_limit = $urandom_range(0, 64);
    end else begin
      it.cmd = CMD_INSERT;
      it.name_len = LEN_W'($urandom_range(3000, 4064));
      it.value_len = LEN_W'($urandom_range(0, 32));
    end
    queue_item(it);
  endtask

  // Hold until every queued item is taken and every result has come back
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_valid || awaited_rsps.size() != 0)
      @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // Drive request items; hold a stalled item until it is taken
  always @(negedge clk) begin
    if (!rst) begin
      if (req_valid && !req_taken) begin
        req_valid <= 1'b1;
      end else if (req_gap != 0) begin
        req_gap <= req_gap - 1;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() != 0 && !no_idle && cycle_no[7] &&
                   $urandom_range(0, 7) == 0) begin
        req_gap <= $urandom_range(0, 3);
        req_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        req <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel in short bursts
  always @(negedge clk) begin
    if (rsp_gap != 0) begin
      rsp_gap <= rsp_gap - 1;
      rsp_stall <= 1'b1;
    end else if (!no_idle && cycle_no[6] && $urandom_range(0, 5) == 0) begin
      rsp_gap <= $urandom_range(0, 3);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Check results, predict on each accepted item, and watch for a hang
  always @(posedge clk) begin : monitor_blk
    out_item_t want;
    cycle_no <= cycle_no + 1;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && !req_stall;
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsps.size() == 0) begin
          $error("unexpected result: status %0d id %0d size %0d", rsp.status, rsp.entry_id,
                 rsp.entry_size);
          mismatches++;
        end else begin
          want = awaited_rsps.pop_front();
          compare_field("status", ID_W'(want.status), ID_W'(rsp.status));
          compare_field("entry_id", want.entry_id, rsp.entry_id);
          compare_field("entry_size", ID_W'(want.entry_size), ID_W'(rsp.entry_size));
          compare_field("used_size", ID_W'(want.used_size), ID_W'(rsp.used_size));
          compare_field("evicted", ID_W'(want.evicted), ID_W'(rsp.evicted));
        end
      end
      if (req_valid && !req_stall) awaited_rsps.push_back(predict_result(req));
    end
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("header_table_size_evict_fifo verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // unused command on the empty table, then a miss
    queue_item(make_item(CMD_NONE, 0, 0, 0, 0));
    queue_item(make_item(CMD_LOOKUP, 0, 0, 1, 0));
    // smallest entry, then one exactly at the limit that evicts everything
    queue_item(make_item(CMD_INSERT, 0, 0, 0, 0));
    queue_item(make_item(CMD_INSERT, 4064, 0, 0, 0));
    // oversized lengths: too large, table emptied, size saturated
    queue_item(make_item(CMD_INSERT, 8191, 8191, 0, 0));
    // too large on an already empty table
    queue_item(make_item(CMD_INSERT, 4065, 0, 0, 0));
    queue_item(make_item(CMD_INSERT, 100, 200, 0, 0));
    queue_item(make_item(CMD_LOOKUP, 0, 0, 3, 0));
    queue_item(make_item(CMD_LOOKUP, 0, 0, 2, 0));
    queue_item(make_item(CMD_LOOKUP, 0, 0, 0, 0));
    queue_item(make_item(CMD_LOOKUP, 0, 0, 32'hFFFF_FFFF, 0));
    queue_item(make_item(CMD_LOOKUP, 0, 0, 4, 0));
    queue_item(make_item(CMD_INSERT, 10, 20, 0, 0));
    // limit saturation well above and just above the maximum
    queue_item(make_item(CMD_SET_LIMIT, 0, 0, 0, 32'hFFFF_FFFF));
    queue_item(make_item(CMD_SET_LIMIT, 0, 0, 0, TABLE_LIMIT_MAX + 1));
    queue_item(make_item(CMD_SET_LIMIT, 0, 0, 0, 400));
    queue_item(make_item(CMD_SET_LIMIT, 0, 0, 0, 300));
    // zero limit evicts all, and then even the smallest entry is too large
    queue_item(make_item(CMD_SET_LIMIT, 0, 0, 0, 0));
    queue_item(make_item(CMD_INSERT, 0, 0, 0, 0));
    queue_item(make_item(CMD_SET_LIMIT, 0, 0, 0, TABLE_LIMIT_MAX));
    queue_item(make_item(CMD_INSERT, 13'h0AAA, 0, 0, 0));
    queue_item(make_item(CMD_INSERT, 13'h1555, 13'h0AAA, 0, 0));
    queue_item(make_item(CMD_LOOKUP, 0, 0, 5, 0));
    queue_item(make_item(CMD_NONE, 13'h1FFF, 13'h1FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // let the directed part settle completely before going random
    wait_drained();
    queue_fill_burst();
    while (planned < ITEM_TARGET) begin
      if (!no_idle && planned >= QUIET_START) begin
        wait_drained();
        no_idle = 1'b1;
      end
      if ($urandom_range(0, 299) == 0) queue_fill_burst();
      else queue_item(random_op());
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("header_table_size_evict_fifo verification clean");
    end else begin
      $display("header_table_size_evict_fifo verification failed");
    end
    $finish;
  end

endmodule
